### rtl/mps_pkg.sv
`timescale 1ns / 1ps
// Package for the stepper move phase sequencer.
// Holds command, mode and status codes and the item and result types.
package mps_pkg;

  localparam int unsigned STEP_W = 32;
  localparam logic [STEP_W-1:0] ENDLESS_STEPS = '1;
  localparam logic [STEP_W-1:0] RAMP_RESET = STEP_W'(200);

  localparam logic [2:0] CMD_PHASE_DONE = 3'd0;
  localparam logic [2:0] CMD_FIXED      = 3'd1;
  localparam logic [2:0] CMD_PROFILED   = 3'd2;
  localparam logic [2:0] CMD_CONTINUOUS = 3'd3;
  localparam logic [2:0] CMD_RAMP_STOP  = 3'd4;
  localparam logic [2:0] CMD_STOP       = 3'd5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_NOT_IDLE = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACCEL  = 2'd1,
    MODE_CRUISE = 2'd2,
    MODE_DECEL  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [STEP_W-1:0] step_count;
  } mps_item_t;

  typedef struct packed {
    mode_t             phase_start;
    logic [STEP_W-1:0] phase_steps;
    logic              cruise_endless;
    logic              abort_current;
    logic [1:0]        status;
    logic              move_done;
    mode_t             mode_now;
    logic              busy_res;
  } mps_result_t;

endpackage

### rtl/mps_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the stepper move phase sequencer.
// Depends on mps_pkg for the step width.
interface mps_cmd_if import mps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [STEP_W-1:0] step_count;
  modport source (output valid, command, step_count, input ready);
  modport sink (input valid, command, step_count, output ready);
endinterface

interface mps_res_if import mps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        phase_start;
  logic [STEP_W-1:0] phase_steps;
  logic              cruise_endless;
  logic              abort_current;
  logic [1:0]        status;
  logic              move_done;
  logic [1:0]        mode_now;
  logic              busy_res;
  modport source (output valid, phase_start, phase_steps, cruise_endless, abort_current,
                  status, move_done, mode_now, busy_res, input ready);
  modport sink (input valid, phase_start, phase_steps, cruise_endless, abort_current,
                status, move_done, mode_now, busy_res, output ready);
endinterface

interface mps_cfg_if import mps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] ramp_steps;
  modport source (output valid, ramp_steps, input ready);
  modport sink (input valid, ramp_steps, output ready);
endinterface

### rtl/mps_core.sv
`timescale 1ns / 1ps
// Move state and phase decision logic of the stepper move phase sequencer.
// Depends on mps_pkg; driven by the item register in the top level and feeds its result register.
module mps_core
  import mps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  mps_item_t         item,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_data,
  output mps_result_t       result
);

  mode_t             mode, mode_next;
  logic              pending, pending_next;
  logic [STEP_W-1:0] cruise_left, cruise_left_next;
  logic [STEP_W-1:0] decel_length, decel_length_next;
  logic [STEP_W-1:0] ramp_steps, ramp_steps_next;

  logic [STEP_W:0]   twice_ramp;
  logic              short_move;
  logic [STEP_W-1:0] up_steps, down_steps, cruise_steps;

  assign twice_ramp   = {ramp_steps, 1'b0};
  assign short_move   = {1'b0, item.step_count} < twice_ramp;
  assign up_steps     = short_move ? (item.step_count >> 1) : ramp_steps;
  assign down_steps   = short_move ? (item.step_count - up_steps) : ramp_steps;
  assign cruise_steps = short_move ? '0 : (item.step_count - twice_ramp[STEP_W-1:0]);

  always_comb begin
    mode_next         = mode;
    pending_next      = pending;
    cruise_left_next  = cruise_left;
    decel_length_next = decel_length;
    ramp_steps_next   = ramp_steps;
    result            = '0;
    if (step_en) begin
      unique case (item.command)
        CMD_PHASE_DONE: begin
          if (mode == MODE_ACCEL) begin
            if (pending && cruise_left == '0) begin
              result.phase_start = MODE_DECEL;
              result.phase_steps = decel_length;
              mode_next          = MODE_DECEL;
            end else begin
              result.phase_start    = MODE_CRUISE;
              result.phase_steps    = pending ? cruise_left : ENDLESS_STEPS;
              result.cruise_endless = !pending;
              mode_next             = MODE_CRUISE;
            end
          end else if (mode == MODE_CRUISE) begin
            if (pending) begin
              result.phase_start = MODE_DECEL;
              result.phase_steps = decel_length;
              mode_next          = MODE_DECEL;
            end else begin
              mode_next = MODE_IDLE;
            end
          end else begin
            mode_next = MODE_IDLE;
            if (pending) begin
              pending_next      = 1'b0;
              decel_length_next = ramp_steps;
              result.move_done  = 1'b1;
            end
          end
        end
        CMD_FIXED: begin
          if (item.step_count == '0) begin
            result.status = STATUS_ZERO;
          end else if (mode != MODE_IDLE) begin
            result.status = STATUS_NOT_IDLE;
          end else begin
            pending_next       = 1'b0;
            decel_length_next  = ramp_steps;
            result.phase_start = MODE_CRUISE;
            result.phase_steps = item.step_count;
            mode_next          = MODE_CRUISE;
          end
        end
        CMD_PROFILED: begin
          if (item.step_count == '0) begin
            result.status = STATUS_ZERO;
          end else if (mode != MODE_IDLE) begin
            result.status = STATUS_NOT_IDLE;
          end else begin
            pending_next       = 1'b1;
            cruise_left_next   = cruise_steps;
            decel_length_next  = down_steps;
            result.phase_start = MODE_ACCEL;
            result.phase_steps = up_steps;
            mode_next          = MODE_ACCEL;
          end
        end
        CMD_CONTINUOUS: begin
          if (mode != MODE_IDLE) begin
            result.status = STATUS_NOT_IDLE;
          end else begin
            pending_next       = 1'b0;
            decel_length_next  = ramp_steps;
            result.phase_start = MODE_ACCEL;
            result.phase_steps = ramp_steps;
            mode_next          = MODE_ACCEL;
          end
        end
        CMD_RAMP_STOP: begin
          if (mode == MODE_ACCEL || mode == MODE_CRUISE) begin
            result.abort_current = 1'b1;
            result.phase_start   = MODE_DECEL;
            result.phase_steps   = decel_length;
            mode_next            = MODE_DECEL;
          end
        end
        CMD_STOP: begin
          if (mode != MODE_IDLE) begin
            result.abort_current = 1'b1;
            mode_next            = MODE_IDLE;
            pending_next         = 1'b0;
            decel_length_next    = ramp_steps;
          end
        end
        default: begin
        end
      endcase
      result.mode_now = mode_next;
      result.busy_res = (mode_next != MODE_IDLE) || pending_next;
    end else if (cfg_we && mode == MODE_IDLE && !pending) begin
      ramp_steps_next   = cfg_data;
      decel_length_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      pending      <= 1'b0;
      cruise_left  <= '0;
      decel_length <= RAMP_RESET;
      ramp_steps   <= RAMP_RESET;
    end else begin
      mode         <= mode_next;
      pending      <= pending_next;
      cruise_left  <= cruise_left_next;
      decel_length <= decel_length_next;
      ramp_steps   <= ramp_steps_next;
    end
  end

  a_decel_tracks_ramp: assert property (@(posedge clk) disable iff (rst)
    !pending |-> decel_length == ramp_steps)
    else $error("decel length differs from ramp with no profiled move");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step_en && result.status != STATUS_OK |=> $stable(mode) && $stable(pending))
    else $error("rejected command changed move state");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && result.move_done |=> mode == MODE_IDLE && !pending)
    else $error("move done left the sequencer busy");

  a_endless_only_unprofiled: assert property (@(posedge clk) disable iff (rst)
    step_en && result.cruise_endless |=> mode == MODE_CRUISE && !pending)
    else $error("endless cruise started on a profiled move");

endmodule

### rtl/stepper_move_phase_sequencer.sv
`timescale 1ns / 1ps
// Top level of the stepper move phase sequencer.
// Depends on mps_pkg, the channel interfaces in mps_if and mps_core.
//
// Usage:
//   cmd takes one item per accepted handshake: a command (phase done, fixed
//   run, profiled run, continuous, ramp stop, stop) and a step count.
//   res returns exactly one result item per command item, in order: the
//   phase for the pulse generator to start, its step count, abort, status,
//   move done, the new mode and the busy flag.
//   cfg writes ramp_steps; the write is dropped while a move is in progress.
//   Each accepted item passes the item register, then the result register.
//   Throughput is one item per cycle while res does not stall: these form a
//   two-stage pipeline, and the move state is updated as each item leaves
//   the item register, so each item sees the state its predecessor left.
//   When res stalls, the result is held and one more item is taken into the
//   item register; cmd.ready then drops until res drains.
//   Reset clears both pipeline stages, sets the mode to idle and the ramp
//   length to 200 steps.
module stepper_move_phase_sequencer
  import mps_pkg::*;
(
  input logic     clk,
  input logic     rst,
  mps_cmd_if.sink   cmd,
  mps_res_if.source res,
  mps_cfg_if.sink   cfg
);

  logic        item_valid;
  mps_item_t   item;
  logic        res_valid;
  mps_result_t res_data;
  mps_result_t result;
  logic        advance;
  logic        step_en;

  assign advance   = !res_valid || res.ready;
  assign step_en   = item_valid && advance;
  assign cmd.ready = !item_valid || advance;
  assign cfg.ready = !step_en;

  mps_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step_en),
    .item     (item),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.ramp_steps),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.command    <= cmd.command;
      item.step_count <= cmd.step_count;
    end
    if (step_en) begin
      res_data <= result;
    end
  end

  assign res.valid          = res_valid;
  assign res.phase_start    = res_data.phase_start;
  assign res.phase_steps    = res_data.phase_steps;
  assign res.cruise_endless = res_data.cruise_endless;
  assign res.abort_current  = res_data.abort_current;
  assign res.status         = res_data.status;
  assign res.move_done      = res_data.move_done;
  assign res.mode_now       = res_data.mode_now;
  assign res.busy_res       = res_data.busy_res;

endmodule

### tb/sv/mps_move_checker.sv
`timescale 1ns / 1ps
// Checker for the stepper move phase sequencer: watches cmd, res and cfg,
// predicts each result from its own copy of the move state and compares.
// Depends on mps_pkg and the channel interfaces in mps_if.
module mps_move_checker
  import mps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mps_cmd_if   cmd,
  mps_res_if   res,
  mps_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  logic [STEP_W-1:0] ramp_len;
  logic [STEP_W-1:0] decel_len;
  logic [STEP_W-1:0] cruise_rem;
  mode_t             mode;
  logic              profiled;
  mps_result_t       awaited_res[$];

  function automatic mps_result_t advance_move(input logic [2:0] code,
                                               input logic [STEP_W-1:0] steps);
    mps_result_t r;
    logic [STEP_W-1:0] up;
    logic [STEP_W-1:0] down;
    r = '0;
    case (code)
      CMD_PHASE_DONE: begin
        if (mode == MODE_ACCEL) begin
          if (profiled && cruise_rem == '0) begin
            r.phase_start = MODE_DECEL;
            r.phase_steps = decel_len;
            mode = MODE_DECEL;
          end else begin
            r.phase_start    = MODE_CRUISE;
            r.phase_steps    = profiled ? cruise_rem : ENDLESS_STEPS;
            r.cruise_endless = !profiled;
            mode = MODE_CRUISE;
          end
        end else if (mode == MODE_CRUISE) begin
          if (profiled) begin
            r.phase_start = MODE_DECEL;
            r.phase_steps = decel_len;
            mode = MODE_DECEL;
          end else begin
            mode = MODE_IDLE;
          end
        end else begin
          mode = MODE_IDLE;
          if (profiled) begin
            profiled    = 1'b0;
            decel_len   = ramp_len;
            r.move_done = 1'b1;
          end
        end
      end
      CMD_FIXED: begin
        if (steps == '0) begin
          r.status = STATUS_ZERO;
        end else if (mode != MODE_IDLE) begin
          r.status = STATUS_NOT_IDLE;
        end else begin
          profiled      = 1'b0;
          decel_len     = ramp_len;
          r.phase_start = MODE_CRUISE;
          r.phase_steps = steps;
          mode = MODE_CRUISE;
        end
      end
      CMD_PROFILED: begin
        if (steps == '0) begin
          r.status = STATUS_ZERO;
        end else if (mode != MODE_IDLE) begin
          r.status = STATUS_NOT_IDLE;
        end else begin
          up   = ramp_len;
          down = ramp_len;
          if ({1'b0, steps} < {ramp_len, 1'b0}) begin
            up   = steps >> 1;
            down = steps - up;
          end
          profiled      = 1'b1;
          cruise_rem    = steps - up - down;
          decel_len     = down;
          r.phase_start = MODE_ACCEL;
          r.phase_steps = up;
          mode = MODE_ACCEL;
        end
      end
      CMD_CONTINUOUS: begin
        if (mode != MODE_IDLE) begin
          r.status = STATUS_NOT_IDLE;
        end else begin
          profiled      = 1'b0;
          decel_len     = ramp_len;
          r.phase_start = MODE_ACCEL;
          r.phase_steps = ramp_len;
          mode = MODE_ACCEL;
        end
      end
      CMD_RAMP_STOP: begin
        if (mode == MODE_ACCEL || mode == MODE_CRUISE) begin
          r.abort_current = 1'b1;
          r.phase_start   = MODE_DECEL;
          r.phase_steps   = decel_len;
          mode = MODE_DECEL;
        end
      end
      CMD_STOP: begin
        if (mode != MODE_IDLE) begin
          r.abort_current = 1'b1;
          mode      = MODE_IDLE;
          profiled  = 1'b0;
          decel_len = ramp_len;
        end
      end
      default: begin
      end
    endcase
    r.mode_now = mode;
    r.busy_res = (mode != MODE_IDLE) || profiled;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch_blk
    mps_result_t want;
    if (rst) begin
      ramp_len   = RAMP_RESET;
      decel_len  = RAMP_RESET;
      cruise_rem = '0;
      mode       = MODE_IDLE;
      profiled   = 1'b0;
      awaited_res.delete();
    end else begin
      if (cfg.valid && cfg.ready && mode == MODE_IDLE && !profiled) begin
        ramp_len  = cfg.ramp_steps;
        decel_len = cfg.ramp_steps;
      end
      if (res.valid && res.ready) begin
        if (awaited_res.size() == 0) begin
          $error("result item arrived with no command item waiting");
          errors++;
        end else begin
          want = awaited_res.pop_front();
          check_field("phase_start", 32'(want.phase_start), 32'(res.phase_start));
          check_field("phase_steps", want.phase_steps, res.phase_steps);
          check_field("cruise_endless", 32'(want.cruise_endless),
                      32'(res.cruise_endless));
          check_field("abort_current", 32'(want.abort_current),
                      32'(res.abort_current));
          check_field("status", 32'(want.status), 32'(res.status));
          check_field("move_done", 32'(want.move_done), 32'(res.move_done));
          check_field("mode_now", 32'(want.mode_now), 32'(res.mode_now));
          check_field("busy_res", 32'(want.busy_res), 32'(res.busy_res));
        end
      end
      if (cmd.valid && cmd.ready) begin
        awaited_res.push_back(advance_move(cmd.command, cmd.step_count));
      end
    end
    pending = awaited_res.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the stepper move phase sequencer testbench: clock, reset, command
// and ramp stimulus, receiver stalls and the verdict.
// Depends on mps_pkg, mps_if, the sequencer RTL and mps_move_checker.
module tb_top;
  import mps_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 115;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst;
  int                idle_pct;
  int                stall_pct;
  int                hold_len;
  int                sent;
  int                cycles;
  int                fail_count;
  int                open_count;
  logic [STEP_W-1:0] ramp_now;

  mps_cmd_if cmd_ch ();
  mps_res_if res_ch ();
  mps_cfg_if cfg_ch ();

  stepper_move_phase_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  mps_move_checker move_chk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .errors  (fail_count),
    .pending (open_count)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver_blk
    int n;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [2:0] code, input logic [STEP_W-1:0] steps);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= code;
    cmd_ch.step_count <= steps;
    do @(posedge clk); while (!cmd_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (open_count != 0) @(negedge clk);
  endtask

  task automatic write_ramp(input logic [STEP_W-1:0] value);
    cmd_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.ramp_steps <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    ramp_now = value;
  endtask

  function automatic logic [STEP_W-1:0] pick_steps();
    logic [STEP_W:0]   twice;
    logic [STEP_W-1:0] sat;
    twice = {ramp_now, 1'b0};
    sat   = twice[STEP_W] ? '1 : twice[STEP_W-1:0];
    case ($urandom_range(9))
      0: return '0;
      1: return STEP_W'(1);
      2: return '1;
      3: return sat;
      4: return sat - 1;
      5: return sat + 1;
      6: return $urandom();
      default: return $urandom_range(1, (ramp_now < 2000) ? 3 * ramp_now + 3 : 6000);
    endcase
  endfunction

  function automatic logic [2:0] pick_follow_up();
    int r;
    r = $urandom_range(99);
    if (r < 80) return CMD_PHASE_DONE;
    if (r < 88) return CMD_RAMP_STOP;
    if (r < 94) return CMD_STOP;
    return 3'($urandom_range(7));
  endfunction

  task automatic run_move();
    int r;
    int follow;
    r = $urandom_range(99);
    if (r < 35) begin
      send_item(CMD_PROFILED, pick_steps());
      follow = 3;
    end else if (r < 55) begin
      send_item(CMD_CONTINUOUS, $urandom());
      follow = $urandom_range(2, 3);
    end else if (r < 70) begin
      send_item(CMD_FIXED, pick_steps());
      follow = 1;
    end else begin
      send_item(3'($urandom_range(7)), pick_steps());
      follow = $urandom_range(2);
    end
    repeat (follow) send_item(pick_follow_up(), $urandom());
  endtask

  initial begin : stimulus_blk
    logic [STEP_W-1:0] ramp_val;
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_PHASE_DONE;
    cmd_ch.step_count  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.ramp_steps  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 0;
    ramp_now  = RAMP_RESET;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // idle rejections and ignored commands
    send_item(CMD_FIXED, '0);
    send_item(CMD_PROFILED, '0);
    send_item(CMD_PHASE_DONE, '1);
    send_item(CMD_RAMP_STOP, '0);
    send_item(CMD_STOP, '0);
    send_item(CMD_SPARE_LO, '0);
    send_item(CMD_SPARE_HI, '1);
    // full profiled move, with rejections while busy
    send_item(CMD_PROFILED, '1);
    send_item(CMD_FIXED, STEP_W'(5));
    send_item(CMD_PROFILED, '0);
    send_item(CMD_CONTINUOUS, '0);
    repeat (3) send_item(CMD_PHASE_DONE, '0);
    // short move with halved ramps and no cruise
    send_item(CMD_PROFILED, STEP_W'(3));
    send_item(CMD_PHASE_DONE, '0);
    send_item(CMD_RAMP_STOP, '0);
    send_item(CMD_PHASE_DONE, '0);
    // continuous with ramp stop, then a fixed run and a stopped profiled move
    send_item(CMD_CONTINUOUS, '1);
    send_item(CMD_PHASE_DONE, '0);
    send_item(CMD_RAMP_STOP, '0);
    send_item(CMD_PHASE_DONE, '0);
    send_item(CMD_FIXED, STEP_W'(1));
    send_item(CMD_PHASE_DONE, '0);
    send_item(CMD_PROFILED, STEP_W'(400));
    send_item(CMD_STOP, '0);
    // ramp write while moving is dropped
    send_item(CMD_CONTINUOUS, '0);
    write_ramp(STEP_W'(7));
    send_item(CMD_STOP, '0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: ramp_val = STEP_W'(1);
        1: ramp_val = '1;
        2: ramp_val = $urandom_range(2, 12);
        3: ramp_val = '0;
        4: ramp_val = $urandom_range(1, 40);
        5: ramp_val = $urandom();
        6: ramp_val = {1'b1, {(STEP_W-1){1'b0}}};
        default: ramp_val = STEP_W'(3);
      endcase
      if (p != 2) send_item(CMD_STOP, '0);
      write_ramp(ramp_val);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct  = 20;
          stall_pct = 20;
        end
      endcase
      if (p == 4) hold_len = 80;
      for (int goal = sent + PHASE_ITEMS; sent < goal; ) run_move();
    end

    cmd_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
